### rtl/swarl_pkg.sv
// ----------------------------------------------------------------------------
// swarl_pkg
// Shared types and constants of the sliding-window alert rate limiter.
// ----------------------------------------------------------------------------
package swarl_pkg;

  // Verdict codes carried on the result channel
  localparam logic [1:0] VERDICT_ALLOW    = 2'd0;
  localparam logic [1:0] VERDICT_COOLDOWN = 2'd1;
  localparam logic [1:0] VERDICT_LIMIT    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALERT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LEN  = 2'd1;
  localparam logic [1:0] CFG_COOLDOWN    = 2'd2;

  // Configuration reset values
  localparam logic [3:0]  ALERT_LIMIT_RST = 4'd5;
  localparam logic [31:0] WINDOW_LEN_RST  = 32'd60000;
  localparam logic [31:0] COOLDOWN_RST    = 32'd30000;

  // Saturation point of the suppressed-item counter
  localparam logic [31:0] SUPP_MAX = 32'hFFFF_FFFF;

  // Configuration as seen by the core
  typedef struct packed {
    logic [3:0]  alert_limit;
    logic [31:0] window_length_ms;
    logic [31:0] cooldown_length_ms;
  } cfg_t;

endpackage

### rtl/swarl_ring.sv
// ----------------------------------------------------------------------------
// swarl_ring
// Timestamp ring storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swarl_ring #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 48,
  parameter int AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swarl_core.sv
// ----------------------------------------------------------------------------
// swarl_core
// Per-item sequencer: cooldown check, expiry walk over the ring, limit
// decision and append, plus the result register.
// ----------------------------------------------------------------------------
module swarl_core
  import swarl_pkg::*;
#(
  parameter int RING_DEPTH = 8,
  parameter int TIME_WIDTH = 48,
  parameter int IDX_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_WIDTH-1:0] request_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  allowed_o,
  output logic [1:0]            verdict_code_o,
  output logic [3:0]            entries_in_window_o,
  output logic [31:0]           suppressed_total_o,
  output logic                  mem_we_o,
  output logic [IDX_W-1:0]      mem_waddr_o,
  output logic [TIME_WIDTH-1:0] mem_wdata_o,
  output logic [IDX_W-1:0]      mem_raddr_o,
  input  logic [TIME_WIDTH-1:0] mem_rdata_i
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int LIM_W = (CNT_W > 4) ? CNT_W : 4;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [TIME_WIDTH-1:0] cool_end_q, cool_end_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [31:0]           supp_q, supp_d;
  logic [1:0]            verdict_q, verdict_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_verdict_q;
  logic [CNT_W-1:0]      out_cnt_q;
  logic [31:0]           out_supp_q;
  logic                  out_load;

  logic [IDX_W-1:0]      head_inc, tail_inc;
  logic [31:0]           supp_inc;
  logic [TIME_WIDTH-1:0] age;
  logic                  expired;
  logic [LIM_W-1:0]      lim_raw, lim_eff;
  logic                  ring_full;
  logic [TIME_WIDTH:0]   end_sum;
  logic [TIME_WIDTH-1:0] end_sat;
  logic [CNT_W+3:0]      cnt_ext;

  // Pointer wrap and saturating counter
  assign head_inc = (head_q == IDX_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == IDX_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign supp_inc = (supp_q == SUPP_MAX) ? supp_q : supp_q + 32'd1;

  // Age of the oldest entry, modulo the time width
  assign age     = time_q - mem_rdata_i;
  assign expired = age > TIME_WIDTH'(cfg_i.window_length_ms);

  // Effective limit: zero acts as one, clipped to the ring depth
  assign lim_raw   = LIM_W'(cfg_i.alert_limit);
  assign lim_eff   = (lim_raw == '0) ? LIM_W'(1) :
                     (lim_raw > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH) : lim_raw;
  assign ring_full = LIM_W'(count_q) >= lim_eff;

  // Cooldown end, saturating at the top of the time range
  assign end_sum = {1'b0, time_q} + (TIME_WIDTH + 1)'(cfg_i.cooldown_length_ms);
  assign end_sat = end_sum[TIME_WIDTH] ? '1 : end_sum[TIME_WIDTH-1:0];

  // Ring read: head while checking, next head while walking
  assign mem_raddr_o = (state_q == S_READ) ? head_inc : head_q;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = time_q;
  assign mem_we_o    = (state_q == S_DECIDE) && !ring_full;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    cool_end_d = cool_end_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    supp_d     = supp_q;
    verdict_d  = verdict_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          time_d  = request_time_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (time_q < cool_end_q) begin
          supp_d    = supp_inc;
          verdict_d = VERDICT_COOLDOWN;
          state_d   = S_FIN;
        end else if (count_q == '0) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (expired) begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (ring_full) begin
          cool_end_d = end_sat;
          supp_d     = supp_inc;
          verdict_d  = VERDICT_LIMIT;
        end else begin
          tail_d    = tail_inc;
          count_d   = count_q + 1'b1;
          verdict_d = VERDICT_ALLOW;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cool_end_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      supp_q     <= '0;
    end else begin
      state_q    <= state_d;
      cool_end_q <= cool_end_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      supp_q     <= supp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q    <= time_d;
    verdict_q <= verdict_d;
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_verdict_q <= verdict_q;
      out_cnt_q     <= count_q;
      out_supp_q    <= supp_q;
    end
  end

  assign cnt_ext             = {4'b0, out_cnt_q};
  assign out_valid_o         = out_valid_q;
  assign allowed_o           = (out_verdict_q == VERDICT_ALLOW);
  assign verdict_code_o      = out_verdict_q;
  assign entries_in_window_o = cnt_ext[3:0];
  assign suppressed_total_o  = out_supp_q;

`ifndef SYNTH
  // An expired entry leaves the ring one at a time
  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) && expired |=> count_q == $past(count_q) - 1'b1)
    else $error("expiry walk did not drop exactly one entry");

  // Results enter the output register only from the finish step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result loaded outside the finish step");

  // An allowed item always leaves at least one entry in the window
  a_allow_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_verdict_q == VERDICT_ALLOW) |-> out_cnt_q != '0)
    else $error("allowed item with an empty window");

  // The suppressed count never goes down
  a_supp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 supp_q >= $past(supp_q))
    else $error("suppressed count decreased");

  // The fill never passes the ring depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> LIM_W'(count_q) < LIM_W'(RING_DEPTH))
    else $error("append into a full ring");
`endif

endmodule

### rtl/sliding_window_alert_rate_limiter.sv
// ----------------------------------------------------------------------------
// sliding_window_alert_rate_limiter
// Alert rate limiter over a sliding time window, with a cooldown after the
// limit is hit and a saturating count of suppressed alerts.
//
//   Channel   Handshake              Payload
//   in        in_valid_i/in_ready_o  request_time_i
//   out       out_valid_o/out_ready_i allowed_o, verdict_code_o,
//                                    entries_in_window_o, suppressed_total_o
//   cfg       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// One item at a time: accept, cooldown check, then one ring read per cycle
// (each dropped entry, plus any live entry that stops the walk), the decide
// step and the result load, which waits while the output register is full.
// An item refused in cooldown goes from the check straight to the result load.
// The next item is taken while a result still waits in the output register.
// Reset clears control state and loads the register defaults; no clearing
// pass is needed since the ring is read only where it was written.
// ----------------------------------------------------------------------------
module sliding_window_alert_rate_limiter
  import swarl_pkg::*;
#(
  parameter int RING_DEPTH = 8,
  parameter int TIME_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_WIDTH-1:0] request_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  allowed_o,
  output logic [1:0]            verdict_code_o,
  output logic [3:0]            entries_in_window_o,
  output logic [31:0]           suppressed_total_o
);

  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  cfg_t                  cfg_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [TIME_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [TIME_WIDTH-1:0] mem_rdata;

  // Configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alert_limit        <= ALERT_LIMIT_RST;
      cfg_q.window_length_ms   <= WINDOW_LEN_RST;
      cfg_q.cooldown_length_ms <= COOLDOWN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALERT_LIMIT: cfg_q.alert_limit        <= cfg_wdata_i[3:0];
        CFG_WINDOW_LEN:  cfg_q.window_length_ms   <= cfg_wdata_i;
        CFG_COOLDOWN:    cfg_q.cooldown_length_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  swarl_core #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .request_time_i      (request_time_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .allowed_o           (allowed_o),
    .verdict_code_o      (verdict_code_o),
    .entries_in_window_o (entries_in_window_o),
    .suppressed_total_o  (suppressed_total_o),
    .mem_we_o            (mem_we),
    .mem_waddr_o         (mem_waddr),
    .mem_wdata_o         (mem_wdata),
    .mem_raddr_o         (mem_raddr),
    .mem_rdata_i         (mem_rdata)
  );

  swarl_ring #(
    .DEPTH (RING_DEPTH),
    .WIDTH (TIME_WIDTH),
    .AW    (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window alert rate limiter. Requests with
// rising, wrapping and random timestamps are pushed through the valid/ready
// ports under several register settings. A scoreboard keeps its own window
// ring, cooldown and suppression count, and it checks each verdict in order.
// ----------------------------------------------------------------------------
module tb;
  import swarl_pkg::*;

  localparam int          RING_SLOTS      = 8;
  localparam logic [47:0] TIME_MAX        = 48'hFFFF_FFFF_FFFF;
  localparam logic [1:0]  CFG_SPARE       = 2'd3;  // unmapped index, must be ignored
  localparam int          SETTLE_CYCLES   = 16;    // extra wait once no verdict is outstanding
  localparam int          HOLD_OFF_CYCLES = 200;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          ITEMS_PER_PHASE = 75;
  localparam int          REPORT_LIMIT    = 20;

  // Verdict as it appears on the result port
  typedef struct packed {
    logic        allowed;
    logic [1:0]  code;
    logic [3:0]  entries;
    logic [31:0] total;
  } verdict_t;

  // Window predictor plus queue of pending verdicts
  class rate_limit_scoreboard;
    logic [47:0] stamp_ring [RING_SLOTS];
    logic [2:0]  head;
    int unsigned fill;
    logic [47:0] cooldown_end_q;
    logic [31:0] suppressed;
    logic [3:0]  limit_q;
    logic [31:0] window_q;
    logic [31:0] cooldown_q;
    verdict_t    expected_verdicts[$];
    int unsigned mismatches;
    int unsigned verdict_tally[3];

    function new();
      limit_q        = ALERT_LIMIT_RST;
      window_q       = WINDOW_LEN_RST;
      cooldown_q     = COOLDOWN_RST;
      head           = '0;
      fill           = 0;
      cooldown_end_q = '0;
      suppressed     = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
        CFG_ALERT_LIMIT: limit_q    = value[3:0];
        CFG_WINDOW_LEN:  window_q   = value;
        CFG_COOLDOWN:    cooldown_q = value;
        default: ;
      endcase
    endfunction

    function void count_suppressed();
      if (suppressed != SUPP_MAX) suppressed++;
    endfunction

    // Work out the verdict of one accepted request
    function void note_request(input logic [47:0] stamp);
      verdict_t    v;
      int unsigned cap;
      logic [47:0] age;
      logic [48:0] sum;
      logic [2:0]  slot;
      v = '0;
      if (stamp < cooldown_end_q) begin
        count_suppressed();
        v.code = VERDICT_COOLDOWN;
      end else begin
        // limit 0 behaves as 1, anything above the ring depth as full depth
        cap = (limit_q == 0) ? 1 : ((limit_q > RING_SLOTS) ? RING_SLOTS : limit_q);
        // expire oldest first; ages wrap at 48 bits
        while (fill > 0) begin
          age = stamp - stamp_ring[head];
          if (age <= {16'd0, window_q}) break;
          head = head + 3'd1;
          fill--;
        end
        if (fill >= cap) begin
          sum            = {1'b0, stamp} + {17'd0, cooldown_q};
          cooldown_end_q = sum[48] ? TIME_MAX : sum[47:0];
          count_suppressed();
          v.code = VERDICT_LIMIT;
        end else begin
          slot             = head + fill[2:0];
          stamp_ring[slot] = stamp;
          fill++;
          v.allowed = 1'b1;
          v.code    = VERDICT_ALLOW;
        end
      end
      v.entries = fill[3:0];
      v.total   = suppressed;
      expected_verdicts.push_back(v);
      verdict_tally[v.code]++;
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, got allowed=%0d code=%0d",
                   $time, got.allowed, got.code);
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("allowed", want.allowed, got.allowed);
      compare_field("verdict_code", want.code, got.code);
      compare_field("entries_in_window", want.entries, got.entries);
      compare_field("suppressed_total", want.total, got.total);
    endfunction

    function int unsigned outstanding();
      return expected_verdicts.size();
    endfunction

    function int unsigned entries_held();
      return fill;
    endfunction

    // time at which the oldest held stamp sits exactly at the window edge
    function logic [47:0] oldest_expiry();
      return (fill == 0) ? '0 : stamp_ring[head] + {16'd0, window_q};
    endfunction

    function logic [47:0] cooldown_release();
      return cooldown_end_q;
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = CFG_ALERT_LIMIT;
  logic [31:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [47:0] request_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        allowed_o;
  logic [1:0]  verdict_code_o;
  logic [3:0]  entries_in_window_o;
  logic [31:0] suppressed_total_o;

  rate_limit_scoreboard sb = new();
  bit          no_gaps      = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned sent         = 0;
  int unsigned settings     = 0;

  sliding_window_alert_rate_limiter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .request_time_i      (request_time_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .allowed_o           (allowed_o),
    .verdict_code_o      (verdict_code_o),
    .entries_in_window_o (entries_in_window_o),
    .suppressed_total_o  (suppressed_total_o)
  );

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Offer one request, after a random gap unless no_gaps is set, and hold it until taken
  task automatic send_request(input logic [47:0] stamp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    request_time_i <= stamp;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_request(stamp);
    sent++;
  endtask

  // Stop offering and wait until the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all registers back to back, plus the unmapped index
  task automatic write_registers(input logic [31:0] lim, input logic [31:0] win,
                                 input logic [31:0] cool);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ALERT_LIMIT;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_index_i <= CFG_WINDOW_LEN;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_index_i <= CFG_COOLDOWN;
    cfg_wdata_i <= cool;
    @(posedge clk_i);
    cfg_index_i <= CFG_SPARE;
    cfg_wdata_i <= junk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(CFG_ALERT_LIMIT, lim);
    sb.write_reg(CFG_WINDOW_LEN, win);
    sb.write_reg(CFG_COOLDOWN, cool);
    sb.write_reg(CFG_SPARE, junk);
    settings++;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_verdict({allowed_o, verdict_code_o, entries_in_window_o,
                        suppressed_total_o});
    end
  end

  // Stimulus
  initial begin
    logic [47:0] now;
    logic [47:0] stamp;
    logic [31:0] win;
    logic [31:0] cool;
    logic [31:0] span;
    logic [3:0]  lim;
    int          r;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: fill to five, hit the limit, then land inside the cooldown
    for (int k = 0; k < 6; k++) send_request(48'(k * 1000));
    send_request(48'd10000);

    // limit above ring depth, widest window, no cooldown; ages across the wrap
    settle();
    write_registers(32'd15, 32'hFFFF_FFFF, 32'd0);
    send_request(TIME_MAX - 48'd1);
    send_request(TIME_MAX);
    send_request(48'd100000);
    send_request(48'd200000);

    // limit lowered under the current fill: ring is kept, request is refused
    settle();
    write_registers(32'd2, 32'hFFFF_FFFF, 32'd0);
    send_request(48'd300000);
    send_request(48'd300000);

    // limit zero acts as one, zero-length window
    settle();
    write_registers(32'd0, 32'd0, 32'd5);
    send_request(48'd1000000);
    send_request(48'd1000000);
    send_request(48'd1000003);
    send_request(48'd1000005);

    // random phases: rising time with window and cooldown edges, some noise
    now = 48'd2000000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin lim = 4'd1;  win = 32'd60000;     cool = 32'd0;         end
        1:       begin lim = 4'd8;  win = 32'hFFFF_FFFF; cool = 32'hFFFF_FFFF; end
        2:       begin lim = 4'd0;  win = 32'd0;         cool = 32'd7;         end
        3:       begin
          lim  = 4'd15;
          win  = $urandom_range(1, 50);
          cool = $urandom_range(0, 500);
        end
        4:       begin lim = 4'd3;  win = 32'd5000;      cool = 32'd30000;     end
        5:       begin lim = 4'd5;  win = $urandom_range(100, 20000); cool = 32'd0; end
        6:       begin lim = 4'd2;  win = 32'd1;         cool = $urandom_range(1, 20); end
        7:       begin lim = 4'($urandom_range(0, 15)); win = $urandom(); cool = $urandom(); end
        8:       begin lim = 4'd7;  win = 32'd300;       cool = 32'd1000;      end
        default: begin lim = 4'd4;  win = $urandom_range(1000, 100000); cool = 32'd5; end
      endcase
      settle();
      // odd phases put junk in the unused upper bits of the limit word
      write_registers({(phase % 2 == 1) ? 28'($urandom()) : 28'd0, lim}, win, cool);
      no_gaps = (phase == 4 || phase == 7);
      if (phase == 1) hold_off_req = 1'b1;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) settle();
        r = $urandom_range(0, 99);
        if (r < 8) begin
          stamp = {16'($urandom()), 32'($urandom())};
        end else if (r < 16 && sb.entries_held() > 0) begin
          // exactly at, or one past, the window edge of the oldest stamp
          stamp = sb.oldest_expiry() + 48'($urandom_range(0, 1));
          if (stamp > now) now = stamp;
        end else if (sb.cooldown_release() > now &&
                     (r < 24 || (r < 40 && now < sb.cooldown_release()))) begin
          // just before, or right at, the end of the cooldown
          stamp = sb.cooldown_release() - 48'($urandom_range(0, 1));
          now   = stamp;
        end else begin
          span = ($urandom_range(0, 9) < 7) ? win : cool;
          if ($urandom_range(0, 19) == 0)
            now = now + {16'd0, span} * 2 + 48'($urandom_range(0, 1000));
          else
            now = now + 48'($urandom_range(0, span / 3 + 1));
          stamp = now;
        end
        send_request(stamp);
      end
    end

    // cooldown end saturates at the top of the time range
    settle();
    no_gaps = 1'b0;
    write_registers(32'd1, 32'd0, 32'hFFFF_FFFF);
    send_request(TIME_MAX - 48'd5);
    send_request(TIME_MAX - 48'd5);
    send_request(TIME_MAX - 48'd1);
    send_request(TIME_MAX);

    settle();
    $display("Covered %0d requests under %0d register settings, incl. time wrap and saturation.",
             sent, settings + 1);
    $display("Verdicts: %0d allowed, %0d in cooldown, %0d limit hits; %0d mismatches.",
             sb.verdict_tally[VERDICT_ALLOW], sb.verdict_tally[VERDICT_COOLDOWN],
             sb.verdict_tally[VERDICT_LIMIT], sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[sliding_window_alert_rate_limiter] OK");
    end else begin
      $display("[sliding_window_alert_rate_limiter] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("[sliding_window_alert_rate_limiter] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/swarl_pkg.sv
rtl/swarl_ring.sv
rtl/swarl_core.sv
rtl/sliding_window_alert_rate_limiter.sv
test/tb.sv
